### design/bssc_pkg.sv
// ----------------------------------------------------------------------------
// bssc_pkg
// Shared types, constants and modular add for the step sequence counter.
// ----------------------------------------------------------------------------
package bssc_pkg;

    localparam int COUNT_W = 30;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = 11;   // holds value indexes up to 2047

    localparam logic [COUNT_W:0] COUNT_MOD       = 31'd1000000007;
    localparam logic [VAL_W-1:0] MAX_VALUE_RESET = 8'd128;

    typedef struct packed {
        logic [VAL_W-1:0] element_value;
        logic             first_item;
        logic             last_item;
    } bssc_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] way_count;
        logic               is_final;
    } bssc_out_t;

    // per-cycle control fanned out to every cell
    typedef struct packed {
        logic             update;
        logic             shift;
        logic             first_item;
        logic [VAL_W-1:0] element_value;
        logic [VAL_W-1:0] max_value;
    } bssc_cell_ctl_t;

    // both operands below the modulus
    function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                    input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - COUNT_MOD;
        return (s >= COUNT_MOD) ? d[COUNT_W-1:0] : s[COUNT_W-1:0];
    endfunction

endpackage

### design/bssc_cell.sv
// ----------------------------------------------------------------------------
// bssc_cell
// One count of the row: updates from its neighbors, or shifts along the ring.
// ----------------------------------------------------------------------------
module bssc_cell
    import bssc_pkg::*;
#(
    parameter int K = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bssc_cell_ctl_t       ctl,
    input  logic [COUNT_W-1:0]   left_count,
    input  logic [COUNT_W-1:0]   right_count,
    input  logic [COUNT_W-1:0]   shift_in,
    output logic [COUNT_W-1:0]   count_out
);

    localparam logic [IDX_W-1:0] V  = IDX_W'(K + 1);
    localparam logic [IDX_W-1:0] VR = IDX_W'(K + 2);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] upd_value;
    logic [COUNT_W-1:0] right_used;
    logic [IDX_W-1:0]   lim;
    logic [IDX_W-1:0]   ev;
    logic               allowed;

    assign lim = IDX_W'(ctl.max_value);
    assign ev  = IDX_W'(ctl.element_value);

    // v+1 counts only while inside the bound
    assign right_used = (VR <= lim) ? right_count : '0;
    assign allowed    = (V <= lim) && ((ev == '0) || (ev == V));

    always_comb begin
        if (!allowed) begin
            upd_value = '0;
        end else if (ctl.first_item) begin
            upd_value = COUNT_W'(1);
        end else begin
            upd_value = add_mod(add_mod(count_reg, left_count), right_used);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.update) begin
            count_next = upd_value;
        end else if (ctl.shift) begin
            count_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count_out = count_reg;

endmodule

### design/bssc_accum.sv
// ----------------------------------------------------------------------------
// bssc_accum
// Modular running total of the counts leaving the end of the ring.
// ----------------------------------------------------------------------------
module bssc_accum
    import bssc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 clear,
    input  logic                 add_en,
    input  logic [COUNT_W-1:0]   add_value,
    output logic [COUNT_W-1:0]   total
);

    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;

    always_comb begin
        total_next = total_reg;
        if (clear) begin
            total_next = '0;
        end else if (add_en) begin
            total_next = add_mod(total_reg, add_value);
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

### design/bounded_step_sequence_counter.sv
// ----------------------------------------------------------------------------
// bounded_step_sequence_counter
// Counts step-bounded sequences, one element per input word, modulo 1e9+7.
// ----------------------------------------------------------------------------
//
//  channel   ports                      word
//  input     s_valid  s_ready  s_data   element_value, first_item, last_item
//  result    m_valid  m_ready  m_data   way_count, is_final
//  config    cfg_we   cfg_wdata         max_value (no wait, no read-back)
//
//  All counts update in the accept cycle, then the row rotates as a ring
//  past the modular accumulator at its end until every count has passed it,
//  then the total moves to the output register when the register is free.
//  Reset: counts clear to zero, max_value returns to 128.
//  Stalls: the output register holds one result; the next word is accepted
//  while it waits, and the block holds its total until the register frees.
// ----------------------------------------------------------------------------
module bounded_step_sequence_counter
    import bssc_pkg::*;
#(
    parameter int VALUE_LIMIT = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bssc_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bssc_out_t         m_data,
    input  logic              cfg_we,
    input  logic [VAL_W-1:0]  cfg_wdata
);

    localparam int CNT_W = (VALUE_LIMIT > 1) ? $clog2(VALUE_LIMIT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUM  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]   max_value_reg, max_value_next;
    logic               last_reg, last_next;
    logic               m_valid_reg, m_valid_next;
    bssc_out_t          m_data_reg, m_data_next;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic [COUNT_W-1:0] total;
    bssc_cell_ctl_t     ctl;
    logic [COUNT_W-1:0] cnt_w [VALUE_LIMIT];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_HOLD) && out_free;

    // cells see the live input word on the accept edge
    assign ctl.update        = accept;
    assign ctl.shift         = (state_reg == ST_SUM);
    assign ctl.first_item    = s_data.first_item;
    assign ctl.element_value = s_data.element_value;
    assign ctl.max_value     = max_value_reg;

    // row of cells; cell k holds the count for value k+1, the ring closes
    // from the last cell back to cell 0
    for (genvar k = 0; k < VALUE_LIMIT; k++) begin : g_cell
        logic [COUNT_W-1:0] left_c;
        logic [COUNT_W-1:0] right_c;
        logic [COUNT_W-1:0] ring_c;
        if (k == 0) begin : g_first
            assign left_c = '0;
            assign ring_c = cnt_w[VALUE_LIMIT-1];
        end else begin : g_mid
            assign left_c = cnt_w[k-1];
            assign ring_c = cnt_w[k-1];
        end
        if (k == VALUE_LIMIT - 1) begin : g_end
            assign right_c = '0;
        end else begin : g_inner
            assign right_c = cnt_w[k+1];
        end
        bssc_cell #(.K(k)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .left_count  (left_c),
            .right_count (right_c),
            .shift_in    (ring_c),
            .count_out   (cnt_w[k])
        );
    end

    // total of the freshly updated counts as they pass the ring's end
    bssc_accum u_accum (
        .aclk      (aclk),
        .clear     (accept),
        .add_en    (state_reg == ST_SUM),
        .add_value (cnt_w[VALUE_LIMIT-1]),
        .total     (total)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        max_value_next = cfg_we ? cfg_wdata : max_value_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SUM;
                    cnt_next   = '0;
                    last_next  = s_data.last_item;
                end
            end
            ST_SUM: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_LIMIT - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next         = 1'b1;
            m_data_next.way_count = total;
            m_data_next.is_final  = last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            max_value_reg <= MAX_VALUE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            max_value_reg <= max_value_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
